/* rtl/lss_pkg.sv */
package lss_pkg;

    localparam int LANES       = 8;
    localparam int PATTERN_MAX = 32;
    localparam int WIN_LEN     = PATTERN_MAX - 1;
    localparam int PAT_BYTES   = 32;
    localparam int POS_W       = 32;
    localparam int LEN_W       = 6;
    localparam int EL_W        = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W       = 4;
    localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int BASE_W      = POS_W + 2;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH,
        CFG_PATTERN_WORD_0,
        CFG_PATTERN_WORD_1,
        CFG_PATTERN_WORD_2,
        CFG_PATTERN_WORD_3,
        CFG_START_OFFSET
    } t_cfg_index;

    typedef struct packed {
        logic [63:0]      data_bytes;
        logic [CNT_W-1:0] byte_count;
        logic             end_of_stream;
    } t_in;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_start;
        logic             stream_end;
        logic             last_result;
    } t_out;

    typedef struct packed {
        logic [LANES-1:0]  hits;
        logic [BASE_W-1:0] base;
        logic              eos;
    } t_entry;

endpackage

/* rtl/literal_string_search.sv */
// Latency: each result of an item is written into the result queue, then into the output register.
// Throughput: one item per cycle while each item gives at most one result and the output is not
// stalled; an item with several matches gives them one after another, and a four-entry queue absorbs bursts.
// Input is stalled only while that queue is full.
// Reset (synchronous, active low) empties the queue and output, clears the byte window
// and stream position, and sets pattern length 1, pattern zero and start offset 0.
module literal_string_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lss_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lss_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lss_pkg::t_out                 o_out_data
);
    import lss_pkg::*;

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    t_entry entry;
    t_entry head;

    lss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (entry)
    );

    lss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head),
        .i_pop   (pop)
    );

    lss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/lss_front.sv */
module lss_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lss_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lss_pkg::t_in                 i_in_data,
    input  logic                         i_q_full,
    output logic                         o_push,
    output lss_pkg::t_entry              o_entry
);
    import lss_pkg::*;

    localparam int SW = EL_W + 2;

    logic [LEN_W-1:0]               r_len;
    logic [PAT_BYTES*8-1:0]         r_pattern;
    logic [POS_W-1:0]               r_start_offset;
    logic [POS_W-1:0]               r_pos;
    logic [WIN_LEN-1:0][7:0]        r_window;

    logic [EL_W-1:0]                len;
    logic [CNT_W-1:0]               lane_count;
    logic [WIN_LEN+LANES-1:0][7:0]  cat;
    logic [PATTERN_MAX-1:0][7:0]    rpat;
    logic [LANES-1:0]               hits;
    logic                           pos_big;
    logic                           accept;
    logic [POS_W:0]                 pos_sum;
    logic [POS_W-1:0]               n_pos;
    logic [WIN_LEN-1:0][7:0]        n_window;

    always_comb begin
        if (r_len == '0) begin
            len = EL_W'(1);
        end else if (int'(r_len) > PATTERN_MAX) begin
            len = EL_W'(PATTERN_MAX);
        end else begin
            len = EL_W'(r_len);
        end
    end

    assign lane_count = (i_in_data.byte_count > CNT_W'(LANES)) ? CNT_W'(LANES)
                                                               : i_in_data.byte_count;

    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            cat[i] = r_window[i];
        end
        for (int j = 0; j < LANES; j++) begin
            cat[WIN_LEN+j] = (j < int'(lane_count)) ? i_in_data.data_bytes[j*8 +: 8] : 8'h00;
        end
    end

    // Pattern reversed so that element k lines up with the byte k places before the lane.
    always_comb begin
        int idx;
        idx = 0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            idx = int'(len) - 1 - k;
            if (idx >= 0 && idx < PAT_BYTES) begin
                rpat[k] = r_pattern[idx*8 +: 8];
            end else begin
                rpat[k] = 8'h00;
            end
        end
    end

    assign pos_big = r_pos >= POS_W'(PATTERN_MAX);

    always_comb begin
        logic [PATTERN_MAX-1:0] eq;
        logic                   seen_ok;
        eq      = '0;
        seen_ok = 1'b0;
        for (int j = 0; j < LANES; j++) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                eq[k] = (k >= int'(len)) || (cat[WIN_LEN+j-k] == rpat[k]);
            end
            seen_ok = pos_big ||
                      ((SW'(r_pos[EL_W-1:0]) + SW'(j + 1)) >= SW'(len));
            hits[j] = (j < int'(lane_count)) && seen_ok && (&eq);
        end
    end

    assign pos_sum = {1'b0, r_pos} + (POS_W+1)'(lane_count);
    assign n_pos   = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            n_window[i] = cat[i + int'(lane_count)];
        end
    end

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_push     = accept && ((|hits) || i_in_data.end_of_stream);

    assign o_entry.hits = hits;
    assign o_entry.base = BASE_W'(r_start_offset) + BASE_W'(r_pos) + BASE_W'(1)
                          - BASE_W'(len);
    assign o_entry.eos  = i_in_data.end_of_stream;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len          <= LEN_W'(1);
            r_pattern      <= '0;
            r_start_offset <= '0;
            r_window       <= '0;
            r_pos          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_PATTERN_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                    CFG_PATTERN_WORD_0: r_pattern[0*CFG_W +: CFG_W] <= i_cfg_data;
                    CFG_PATTERN_WORD_1: r_pattern[1*CFG_W +: CFG_W] <= i_cfg_data;
                    CFG_PATTERN_WORD_2: r_pattern[2*CFG_W +: CFG_W] <= i_cfg_data;
                    CFG_PATTERN_WORD_3: r_pattern[3*CFG_W +: CFG_W] <= i_cfg_data;
                    CFG_START_OFFSET:   r_start_offset <= i_cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_in_data.end_of_stream) begin
                    r_window <= '0;
                    r_pos    <= '0;
                end else begin
                    r_window <= n_window;
                    r_pos    <= n_pos;
                end
            end
        end
    end

endmodule

/* rtl/lss_fifo.sv */
module lss_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lss_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_empty,
    output lss_pkg::t_entry o_head,
    input  logic            i_pop
);
    import lss_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("Queue count exceeds its depth.");
`endif

endmodule

/* rtl/lss_back.sv */
module lss_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  lss_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lss_pkg::t_out   o_out_data
);
    import lss_pkg::*;

    logic             r_out_valid;
    t_out             r_out;
    logic [LANES-1:0] r_done;

    logic [LANES-1:0]  rem;
    logic [LANES-1:0]  lowest;
    logic [LANE_W-1:0] lane_idx;
    logic              rest_zero;
    logic              emit;
    logic [BASE_W-1:0] start_sum;
    t_out              n_out;

    assign rem       = i_head.hits & ~r_done;
    assign lowest    = rem & (~rem + LANES'(1));
    assign rest_zero = (rem & ~lowest) == '0;

    always_comb begin
        lane_idx = '0;
        for (int j = 0; j < LANES; j++) begin
            if (lowest[j]) begin
                lane_idx = lane_idx | LANE_W'(j);
            end
        end
    end

    assign emit      = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_pop     = emit && rest_zero;
    assign start_sum = i_head.base + BASE_W'(lane_idx);

    always_comb begin
        n_out.match_found = |rem;
        if (!(|rem)) begin
            n_out.match_start = '0;
        end else if (start_sum[BASE_W-1:POS_W] != '0) begin
            n_out.match_start = '1;
        end else begin
            n_out.match_start = start_sum[POS_W-1:0];
        end
        n_out.stream_end  = i_head.eos && rest_zero;
        n_out.last_result = rest_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (emit) begin
                r_done <= r_done | lowest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_match_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.match_found |->
            o_out_data.stream_end && o_out_data.last_result)
        else $error("Result without a match does not close the stream.");

    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_out_valid && o_out_data.last_result)
        else $error("Finished entry did not leave a last result.");

    a_partial_marks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && !o_pop |=> r_done != '0)
        else $error("Partly delivered entry lost its progress.");
`endif

endmodule

/* test/testbench.sv */
module testbench;
    import lss_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 60;

    class match_tracker;
        logic [5:0]  pat_len;
        logic [63:0] pat_word [4];
        logic [31:0] base_offset;
        logic [7:0]  history [WIN_LEN];
        logic [31:0] bytes_seen;
        t_out        expected_matches [$];
        int          errors;

        function new();
            pat_len     = 6'd1;
            base_offset = '0;
            bytes_seen  = '0;
            errors      = 0;
            foreach (pat_word[k]) pat_word[k] = '0;
            foreach (history[k]) history[k] = '0;
        endfunction

        function void set_register(t_cfg_index idx, logic [63:0] v);
            case (idx)
                CFG_PATTERN_LENGTH: pat_len = v[5:0];
                CFG_PATTERN_WORD_0: pat_word[0] = v;
                CFG_PATTERN_WORD_1: pat_word[1] = v;
                CFG_PATTERN_WORD_2: pat_word[2] = v;
                CFG_PATTERN_WORD_3: pat_word[3] = v;
                CFG_START_OFFSET:   base_offset = v[31:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        // Predicts the results of one accepted transfer and advances the stream state.
        function void note_transfer(t_in it);
            logic [7:0]        joined [WIN_LEN + LANES];
            t_out              found [LANES];
            int                n, len, cnt;
            bit                hit;
            longint unsigned   seen, start, np;
            n   = (it.byte_count > LANES) ? LANES : int'(it.byte_count);
            len = (pat_len == 0) ? 1 : ((pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len));
            cnt = 0;
            for (int k = 0; k < WIN_LEN; k++) joined[k] = history[k];
            for (int k = 0; k < LANES; k++)
                joined[WIN_LEN + k] = (k < n) ? it.data_bytes[k*8 +: 8] : 8'h00;
            for (int j = 0; j < n; j++) begin
                seen = longint'(bytes_seen) + j + 1;
                if (seen >= len) begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++) begin
                        if (joined[WIN_LEN + j + 1 - len + i] != pat_word[i/8][(i%8)*8 +: 8])
                            hit = 1'b0;
                    end
                    if (hit) begin
                        start = longint'(base_offset) + (seen - len);
                        if (start > 64'hFFFF_FFFF) start = 64'hFFFF_FFFF;
                        found[cnt] = '0;
                        found[cnt].match_found = 1'b1;
                        found[cnt].match_start = start[31:0];
                        cnt++;
                    end
                end
            end
            if (it.end_of_stream && cnt == 0) begin
                found[0] = '0;
                cnt = 1;
            end
            if (cnt > 0) begin
                found[cnt-1].stream_end  = it.end_of_stream;
                found[cnt-1].last_result = 1'b1;
            end
            for (int k = 0; k < cnt; k++) expected_matches.push_back(found[k]);
            if (it.end_of_stream) begin
                foreach (history[k]) history[k] = '0;
                bytes_seen = '0;
            end else begin
                for (int k = 0; k < WIN_LEN; k++) history[k] = joined[k + n];
                np = longint'(bytes_seen) + n;
                bytes_seen = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : np[31:0];
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_matches.size() == 0) begin
                errors++;
                $display("%0t: expected no result, actual f=%0b s=%h e=%0b l=%0b",
                         $time, got.match_found, got.match_start, got.stream_end,
                         got.last_result);
                return;
            end
            want = expected_matches.pop_front();
            if (got.match_found !== want.match_found || got.match_start !== want.match_start ||
                got.stream_end !== want.stream_end || got.last_result !== want.last_result) begin
                errors++;
                $display("%0t: expected f=%0b s=%h e=%0b l=%0b, actual f=%0b s=%h e=%0b l=%0b",
                         $time, want.match_found, want.match_start, want.stream_end,
                         want.last_result, got.match_found, got.match_start, got.stream_end,
                         got.last_result);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;

    match_tracker sb = new();
    int           n_in = 0;
    int           quiet = 0;
    logic         calm;
    logic [255:0] stim_pattern = '0;
    int           stim_len = 1;
    int           plant_idx = 1000;

    assign calm = (n_in >= 120) && (n_in < 160);

    literal_string_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_transfer(i_in_data);
            n_in++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch so that the result queue fills.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 29);
            end
        end
    end

    task automatic send_item(logic [63:0] d, logic [3:0] c, logic e);
        while (!calm && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_bytes: d, byte_count: c, end_of_stream: e};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [63:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        sb.set_register(idx, v);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [5:0] len, logic [255:0] pat, logic [31:0] off);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, {58'd0, len});
        write_reg(CFG_PATTERN_WORD_0, pat[63:0]);
        write_reg(CFG_PATTERN_WORD_1, pat[127:64]);
        write_reg(CFG_PATTERN_WORD_2, pat[191:128]);
        write_reg(CFG_PATTERN_WORD_3, pat[255:192]);
        write_reg(CFG_START_OFFSET, {32'd0, off});
        i_cfg_we <= 1'b0;
        stim_pattern = pat;
        stim_len = (len == 0) ? 1 : ((len > PATTERN_MAX) ? PATTERN_MAX : int'(len));
        plant_idx = 1000;
    endtask

    function automatic logic [255:0] rand_pattern();
        logic [255:0] p;
        for (int k = 0; k < 8; k++) p[k*32 +: 32] = $urandom;
        return p;
    endfunction

    // Planted copies of the pattern, some pattern bytes out of order, some noise.
    function automatic logic [7:0] next_byte();
        logic [7:0] b;
        if (plant_idx < stim_len) begin
            b = stim_pattern[plant_idx*8 +: 8];
            plant_idx++;
        end else if ($urandom_range(3) == 0) begin
            b = stim_pattern[7:0];
            plant_idx = 1;
        end else if ($urandom_range(1) == 0) begin
            b = stim_pattern[$urandom_range(stim_len - 1)*8 +: 8];
        end else begin
            b = $urandom;
        end
        return b;
    endfunction

    task automatic send_random();
        logic [63:0] d;
        logic [3:0]  c;
        int          n;
        c = ($urandom_range(99) < 75) ? 4'd8 : 4'($urandom_range(15));
        n = (c > 8) ? 8 : int'(c);
        d = {$urandom, $urandom};
        for (int j = 0; j < n; j++) d[j*8 +: 8] = next_byte();
        send_item(d, c, $urandom_range(11) == 0);
    endtask

    task automatic run_phase(logic [5:0] len, logic [255:0] pat, logic [31:0] off, int cnt);
        configure(len, pat, off);
        repeat (cnt) send_random();
    endtask

    initial begin
        logic [255:0] p;
        logic [7:0]   rb;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting: a single zero byte, so every zero byte matches.
        send_item(64'h0, 4'd8, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_item(64'h00FF_00FF_00FF_00FF, 4'd15, 1'b0);
        send_item(64'h0, 4'd0, 1'b0);
        send_item(64'h0, 4'd0, 1'b1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
        send_item(64'h0, 4'd3, 1'b1);
        send_item(64'hFFFF_FFFF_FFFF_FF00, 4'd9, 1'b0);

        // Zeros held in the window at stream start must not match.
        configure(6'd2, 256'd0, 32'd0);
        send_item(64'h0, 4'd1, 1'b0);
        send_item(64'h0, 4'd1, 1'b0);

        p = rand_pattern();
        configure(6'd32, p, 32'd0);
        send_item(p[63:0], 4'd8, 1'b0);
        send_item(p[127:64], 4'd8, 1'b0);
        send_item(p[191:128], 4'd8, 1'b0);
        send_item(p[255:192], 4'd8, 1'b1);

        configure(6'd1, 256'd0, 32'hFFFF_FFFE);
        send_item(64'h0, 4'd4, 1'b1);

        rb = $urandom;
        run_phase(6'd4, rand_pattern(), $urandom, 34);
        run_phase(6'd0, rand_pattern(), 32'd0, 34);
        run_phase(6'd63, rand_pattern(), 32'hFFFF_FFFF, 34);
        run_phase(6'd3, {32{rb}}, $urandom, 34);
        run_phase(6'($urandom_range(31, 2)), rand_pattern(), 32'hFFFF_FFF0, 34);
        run_phase(6'd32, {256{1'b1}}, 32'd0, 34);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
